FILE: rtl/height_map_grid_classifier_defines.svh
// ----------------------------------------------------------------------------
// Height map grid classifier: assertion macros
// Concurrent assertion wrappers clocked on clk; the first form is disabled
// while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef HEIGHT_MAP_GRID_CLASSIFIER_DEFINES_SVH
`define HEIGHT_MAP_GRID_CLASSIFIER_DEFINES_SVH

`ifndef ASSERT_OFF
`define HMGC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HMGC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HMGC_ASSERT(lbl, prop, msg)
`define HMGC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: rtl/hmgc_pkg.sv
// ----------------------------------------------------------------------------
// Height map grid classifier package
// Grid geometry, register indexes and the structs shared by the top level
// and the cell engine.
// ----------------------------------------------------------------------------
package hmgc_pkg;

  localparam int GRID_DIM = 128;
  localparam int CELLS    = GRID_DIM * GRID_DIM;
  localparam int IDX_W    = (GRID_DIM > 1) ? $clog2(GRID_DIM) : 1;
  localparam int ADDR_W   = $clog2(CELLS);
  // Signed width of floor(coord / 2^shift) + GRID_DIM/2
  localparam int Q_W      = 18;

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CELL_SHIFT = 2'd0,
    CFG_HEIGHT_THR = 2'd1,
    CFG_CAR_HEIGHT = 2'd2
  } cfg_idx_t;

  localparam logic [3:0]         RST_CELL_SHIFT = 4'd9;
  localparam logic [15:0]        RST_HEIGHT_THR = 16'd300;
  localparam logic signed [15:0] RST_CAR_HEIGHT = 16'sd2000;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic              seen;
    logic signed [15:0] min_h;
    logic signed [15:0] max_h;
    logic [15:0]        cnt;
  } cell_t;

  typedef struct packed {
    logic              is_query;
    logic              in_grid;
    logic [ADDR_W-1:0] addr;
    logic signed [15:0] z;
  } req_t;

  typedef struct packed {
    logic signed [15:0] max_height;
    logic signed [15:0] min_height;
    logic [15:0]        point_count;
    logic               is_obstacle;
    logic               cell_seen;
  } res_t;

  typedef struct packed {
    logic [15:0]        height_thr;
    logic signed [15:0] car_height;
  } class_cfg_t;

  typedef struct packed {
    logic clearing;
    logic query_pending;
  } eng_status_t;

endpackage

FILE: rtl/hmgc_cell_engine.sv
// ----------------------------------------------------------------------------
// Height map grid classifier: cell engine
// Holds the per-cell statistics in one synchronous memory, sweeps the seen
// flags clear after reset, and updates or reads and clears one cell per
// transaction with a forwarding path for back-to-back hits on one cell.
// ----------------------------------------------------------------------------
module hmgc_cell_engine import hmgc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  class_cfg_t  cfg,
  input  logic        req_valid,
  input  req_t        req,
  output logic        res_valid,
  output res_t        res,
  output eng_status_t status
);

  cell_t mem [CELLS];

  cell_t             rd_data_r;
  logic              p1_valid_r;
  req_t              p1_req_r;
  logic              fwd_valid_r;
  logic [ADDR_W-1:0] fwd_addr_r;
  cell_t             fwd_data_r;
  logic              clr_active_r;
  logic [ADDR_W-1:0] clr_addr_r;

  cell_t              cur;
  cell_t              upd;
  logic               p1_write;
  logic               we;
  logic [ADDR_W-1:0]  waddr;
  cell_t              wdata;
  logic signed [15:0] hi;
  logic [16:0]        spread;

  // Read port: data for the request appears in the cycle after it
  always_ff @(posedge clk) begin
    rd_data_r <= mem[req.addr];
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Take the write of the previous cycle when it hit this cell
  always_comb begin
    if (fwd_valid_r && (fwd_addr_r == p1_req_r.addr)) begin
      cur = fwd_data_r;
    end else begin
      cur = rd_data_r;
    end
  end

  always_comb begin
    upd = cur;
    if (p1_req_r.is_query) begin
      upd = '0;
    end else if (!cur.seen) begin
      upd.seen  = 1'b1;
      upd.min_h = p1_req_r.z;
      upd.max_h = p1_req_r.z;
      upd.cnt   = 16'd1;
    end else begin
      if (p1_req_r.z < cur.min_h) begin
        upd.min_h = p1_req_r.z;
      end
      if (p1_req_r.z > cur.max_h) begin
        upd.max_h = p1_req_r.z;
      end
      if (cur.cnt != COUNT_MAX) begin
        upd.cnt = cur.cnt + 16'd1;
      end
    end
  end

  // Overhead rule and spread classification
  always_comb begin
    hi     = (cur.min_h >= cfg.car_height) ? cur.min_h : cur.max_h;
    spread = 17'({hi[15], hi} - {cur.min_h[15], cur.min_h});
    res    = '0;
    if (p1_req_r.in_grid && cur.seen) begin
      res.cell_seen   = 1'b1;
      res.is_obstacle = spread > {1'b0, cfg.height_thr};
      res.point_count = cur.cnt;
      res.min_height  = cur.min_h;
      res.max_height  = hi;
    end
  end

  assign res_valid = p1_valid_r && p1_req_r.is_query;
  assign p1_write  = p1_valid_r && (!p1_req_r.is_query || p1_req_r.in_grid);
  assign we        = clr_active_r || p1_write;
  assign waddr     = clr_active_r ? clr_addr_r : p1_req_r.addr;
  assign wdata     = clr_active_r ? cell_t'('0) : upd;

  assign status.clearing      = clr_active_r;
  assign status.query_pending = p1_valid_r && p1_req_r.is_query;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r   <= 1'b0;
      fwd_valid_r  <= 1'b0;
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else begin
      p1_valid_r  <= req_valid;
      fwd_valid_r <= p1_write;
      if (clr_active_r) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == ADDR_W'(CELLS - 1)) begin
          clr_active_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid) begin
      p1_req_r <= req;
    end
    fwd_addr_r <= p1_req_r.addr;
    fwd_data_r <= upd;
  end

endmodule

FILE: rtl/height_map_grid_classifier.sv
// Point add: one transaction per cycle while the output queue has room; the
// cell read-modify-write reads into a register and writes back from p1.
// Query: result passes the engine p1 stage into the two-entry output queue;
// new input waits while the queue and the query in flight would fill it.
// Reset (rst_n low, synchronous) starts a pass that clears all 16384 cells;
// in_tready stays low until it ends. Registers reset to 9/300/2000.
// ----------------------------------------------------------------------------
// Height map grid classifier
// Bins lidar points into a square grid of min/max/count cells and answers
// cell queries with obstacle class and statistics, clearing the cell.
// ----------------------------------------------------------------------------
`include "height_map_grid_classifier_defines.svh"

module height_map_grid_classifier import hmgc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wen,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [15:0]          cfg_wdata,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // x_coord[15:0], y_coord[31:16], z_coord[47:32], query_row[54:48],
  // query_col[61:55], zero[63:62]
  input  logic [63:0]          in_tdata,
  // cmd
  input  logic                 in_tuser,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // cell_seen[0], is_obstacle[1], point_count[17:2], min_height[33:18],
  // max_height[49:34], zero[55:50]
  output logic [55:0]          out_tdata
);

  logic [3:0]         cell_shift_r;
  logic [15:0]        height_thr_r;
  logic signed [15:0] car_height_r;

  logic signed [15:0] x_coord, y_coord, z_coord;
  logic [6:0]         query_row, query_col;
  logic [15:0]        x_sh, y_sh, bias_sh;
  logic [Q_W-1:0]     x_q, y_q;
  logic               x_in, y_in, q_in;
  logic [IDX_W-1:0]   x_idx, y_idx;
  logic               accept;
  req_t               req;
  logic               req_valid;
  class_cfg_t         ccfg;
  logic               res_valid;
  res_t               res;
  eng_status_t        status;

  res_t               fifo_q [2];
  logic               wr_ptr_r, rd_ptr_r;
  logic [1:0]         occ_r;
  logic               pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_shift_r <= RST_CELL_SHIFT;
      height_thr_r <= RST_HEIGHT_THR;
      car_height_r <= RST_CAR_HEIGHT;
    end else if (cfg_wen) begin
      unique case (cfg_addr)
        CFG_CELL_SHIFT: cell_shift_r <= cfg_wdata[3:0];
        CFG_HEIGHT_THR: height_thr_r <= cfg_wdata;
        CFG_CAR_HEIGHT: car_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign x_coord   = in_tdata[15:0];
  assign y_coord   = in_tdata[31:16];
  assign z_coord   = in_tdata[47:32];
  assign query_row = in_tdata[54:48];
  assign query_col = in_tdata[61:55];

  // floor(v / 2^shift) = ((v + 32768) >> shift) - (32768 >> shift)
  assign x_sh    = {~x_coord[15], x_coord[14:0]} >> cell_shift_r;
  assign y_sh    = {~y_coord[15], y_coord[14:0]} >> cell_shift_r;
  assign bias_sh = 16'h8000 >> cell_shift_r;
  assign x_q     = Q_W'(x_sh) - Q_W'(bias_sh) + Q_W'(GRID_DIM / 2);
  assign y_q     = Q_W'(y_sh) - Q_W'(bias_sh) + Q_W'(GRID_DIM / 2);
  assign x_in    = !x_q[Q_W-1] && (x_q < Q_W'(GRID_DIM));
  assign y_in    = !y_q[Q_W-1] && (y_q < Q_W'(GRID_DIM));
  assign x_idx   = x_q[IDX_W-1:0];
  assign y_idx   = y_q[IDX_W-1:0];
  assign q_in    = (Q_W'(query_row) < Q_W'(GRID_DIM)) &&
                   (Q_W'(query_col) < Q_W'(GRID_DIM));

  always_comb begin
    req.is_query = in_tuser;
    req.z        = z_coord;
    if (in_tuser) begin
      req.in_grid = q_in;
      req.addr    = ADDR_W'(ADDR_W'(query_row) * ADDR_W'(GRID_DIM) + ADDR_W'(query_col));
    end else begin
      req.in_grid = x_in && y_in;
      req.addr    = ADDR_W'(ADDR_W'(x_idx) * ADDR_W'(GRID_DIM) + ADDR_W'(y_idx));
    end
  end

  // Leave room in the output queue for the query in flight and this one
  assign in_tready = !status.clearing &&
                     ((3'(occ_r) + 3'(status.query_pending)) <= 3'd1);
  assign accept    = in_tvalid && in_tready;
  // Drop points outside the grid here; queries always produce a result
  assign req_valid = accept && (in_tuser || (x_in && y_in));

  assign ccfg.height_thr = height_thr_r;
  assign ccfg.car_height = car_height_r;

  hmgc_cell_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (ccfg),
    .req_valid (req_valid),
    .req       (req),
    .res_valid (res_valid),
    .res       (res),
    .status    (status)
  );

  assign pop        = out_tvalid && out_tready;
  assign out_tvalid = occ_r != 2'd0;
  assign out_tdata  = {6'd0, fifo_q[rd_ptr_r]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      occ_r    <= 2'd0;
    end else begin
      if (res_valid) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      occ_r <= occ_r + 2'(res_valid) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      fifo_q[wr_ptr_r] <= res;
    end
  end

  `HMGC_ASSERT(a_no_push_when_full, res_valid |-> (occ_r != 2'd2 || pop), "result pushed into full queue")
  `HMGC_ASSERT(a_occ_bound, occ_r != 2'd3, "output queue occupancy overflow")
  `HMGC_ASSERT(a_quiet_while_clearing, status.clearing |-> (!out_tvalid && !status.query_pending), "activity during clearing pass")

endmodule

FILE: test/tb_height_map_grid_classifier.sv
// ----------------------------------------------------------------------------
// Height map grid classifier testbench
// Streams lidar points and cell queries into the grid, keeps its own grid
// model of seen flags, height extremes and counts, and checks every returned
// cell report field by field under changing geometry and threshold settings.
// ----------------------------------------------------------------------------
module tb_height_map_grid_classifier import hmgc_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HALF_GRID     = GRID_DIM / 2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

  typedef enum logic {CMD_ADD = 1'b0, CMD_QUERY = 1'b1} cmd_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_wen;
  logic [CFG_IDX_W-1:0] cfg_addr;
  logic [15:0]          cfg_wdata;
  logic                 in_tvalid;
  logic                 in_tready;
  // x_coord[15:0], y_coord[31:16], z_coord[47:32], query_row[54:48],
  // query_col[61:55], zero[63:62]
  logic [63:0]          in_tdata;
  // cmd
  logic                 in_tuser;
  logic                 out_tvalid;
  logic                 out_tready;
  // cell_seen[0], is_obstacle[1], point_count[17:2], min_height[33:18],
  // max_height[49:34], zero[55:50]
  logic [55:0]          out_tdata;

  // grid model
  cell_t grid_cells [CELLS];
  int    grid_shift;
  int    height_thr;
  int    car_height;
  res_t  cell_reports_due [$];

  int send_idle_pct;
  int recv_idle_pct;
  int mismatch_count;
  int cycle_count;

  height_map_grid_classifier u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // floor(v / 2^shift) + GRID_DIM/2
  function automatic int grid_coord(logic signed [15:0] v);
    int sv;
    sv = v;
    return (sv >>> grid_shift) + HALF_GRID;
  endfunction

  function automatic void update_grid_model(cmd_t cmd, logic signed [15:0] x,
                                            logic signed [15:0] y,
                                            logic signed [15:0] z,
                                            logic [6:0] row, logic [6:0] col);
    int   r, c, k, zi, lo, hi;
    res_t rep;
    zi = z;
    if (cmd == CMD_ADD) begin
      r = grid_coord(x);
      c = grid_coord(y);
      if (r < 0 || r >= GRID_DIM || c < 0 || c >= GRID_DIM) return;
      k = r * GRID_DIM + c;
      if (!grid_cells[k].seen) begin
        grid_cells[k].seen  = 1'b1;
        grid_cells[k].min_h = z;
        grid_cells[k].max_h = z;
        grid_cells[k].cnt   = 16'd1;
      end else begin
        if (zi < int'($signed(grid_cells[k].min_h))) grid_cells[k].min_h = z;
        if (zi > int'($signed(grid_cells[k].max_h))) grid_cells[k].max_h = z;
        if (grid_cells[k].cnt != COUNT_MAX) grid_cells[k].cnt++;
      end
    end else begin
      rep = '0;
      k = int'(row) * GRID_DIM + int'(col);
      if (row < GRID_DIM && col < GRID_DIM && grid_cells[k].seen) begin
        lo = $signed(grid_cells[k].min_h);
        hi = $signed(grid_cells[k].max_h);
        // overhead cell: flatten to its lowest point
        if (lo >= car_height) hi = lo;
        rep.cell_seen   = 1'b1;
        rep.is_obstacle = ((hi - lo) > height_thr);
        rep.point_count = grid_cells[k].cnt;
        rep.min_height  = 16'(lo);
        rep.max_height  = 16'(hi);
        grid_cells[k] = '0;
      end
      cell_reports_due = {cell_reports_due, rep};
    end
  endfunction

  always @(posedge clk) begin : report_check
    res_t got;
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = res_t'(out_tdata[49:0]);
      if (cell_reports_due.size() == 0) begin
        $error("unexpected cell report transaction: %h", out_tdata);
        mismatch_count++;
      end else begin
        want = cell_reports_due.pop_front();
        if (got.cell_seen !== want.cell_seen) begin
          $error("cell_seen: expected %0d, got %0d", want.cell_seen, got.cell_seen);
          mismatch_count++;
        end
        if (got.is_obstacle !== want.is_obstacle) begin
          $error("is_obstacle: expected %0d, got %0d", want.is_obstacle,
                 got.is_obstacle);
          mismatch_count++;
        end
        if (got.point_count !== want.point_count) begin
          $error("point_count: expected %0d, got %0d", want.point_count,
                 got.point_count);
          mismatch_count++;
        end
        if (got.min_height !== want.min_height) begin
          $error("min_height: expected %0d, got %0d", $signed(want.min_height),
                 $signed(got.min_height));
          mismatch_count++;
        end
        if (got.max_height !== want.max_height) begin
          $error("max_height: expected %0d, got %0d", $signed(want.max_height),
                 $signed(got.max_height));
          mismatch_count++;
        end
      end
    end
  end

  // Fields that the command does not use carry random noise.
  task automatic send_item(cmd_t cmd, logic signed [15:0] x, logic signed [15:0] y,
                           logic signed [15:0] z, logic [6:0] row, logic [6:0] col);
    if (cmd == CMD_ADD) begin
      row = 7'($urandom);
      col = 7'($urandom);
    end else begin
      x = 16'($urandom);
      y = 16'($urandom);
      z = 16'($urandom);
    end
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {2'b00, col, row, z, y, x};
    do @(posedge clk); while (!in_tready);
    update_grid_model(cmd, x, y, z, row, col);
  endtask

  // Wait until every report is back and in-flight adds have retired.
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (cell_reports_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] addr, logic [15:0] data);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    case (addr)
      CFG_CELL_SHIFT: grid_shift = data & 16'hF;
      CFG_HEIGHT_THR: height_thr = data;
      CFG_CAR_HEIGHT: car_height = $signed(data);
      default: ;
    endcase
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_item(CMD_QUERY, 0, 0, 0, 7'd5, 7'd7);
    send_item(CMD_ADD, -32768, -32768, -32768, 0, 0);
    send_item(CMD_ADD, 32767, 32767, 32767, 0, 0);
    // spread one above the threshold
    send_item(CMD_ADD, 0, 0, 0, 0, 0);
    send_item(CMD_ADD, 100, 200, 301, 0, 0);
    // spread exactly at the threshold
    send_item(CMD_ADD, -1, -1, 10, 0, 0);
    send_item(CMD_ADD, -1, -1, 310, 0, 0);
    // lowest point at car height: overhead
    send_item(CMD_ADD, 600, 600, 2000, 0, 0);
    send_item(CMD_ADD, 600, 600, 5000, 0, 0);
    send_item(CMD_QUERY, 0, 0, 0, 7'd0, 7'd0);
    send_item(CMD_QUERY, 0, 0, 0, 7'd127, 7'd127);
    send_item(CMD_QUERY, 0, 0, 0, 7'd64, 7'd64);
    send_item(CMD_QUERY, 0, 0, 0, 7'd63, 7'd63);
    send_item(CMD_QUERY, 0, 0, 0, 7'd65, 7'd65);
    send_item(CMD_QUERY, 0, 0, 0, 7'd65, 7'd65);
    drain();
  endtask

  task automatic test_unmapped_register();
    write_reg(CFG_UNMAPPED, 16'h0000);
    send_item(CMD_ADD, 1000, -1000, 42, 0, 0);
    send_item(CMD_QUERY, 0, 0, 0, 7'd65, 7'd62);
    drain();
  endtask

  task automatic test_grid_edges();
    write_reg(CFG_CELL_SHIFT, 16'd0);
    send_item(CMD_ADD, 100, 0, 1, 0, 0);
    send_item(CMD_ADD, -65, 0, 1, 0, 0);
    send_item(CMD_ADD, -64, 63, -5, 0, 0);
    send_item(CMD_ADD, 63, -64, 7, 0, 0);
    send_item(CMD_QUERY, 0, 0, 0, 7'd0, 7'd127);
    send_item(CMD_QUERY, 0, 0, 0, 7'd127, 7'd0);
    send_item(CMD_QUERY, 0, 0, 0, 7'd127, 7'd127);
    drain();
    write_reg(CFG_CELL_SHIFT, 16'd15);
    send_item(CMD_ADD, -1, 0, 7, 0, 0);
    send_item(CMD_ADD, 32767, -32768, 9, 0, 0);
    send_item(CMD_QUERY, 0, 0, 0, 7'd63, 7'd64);
    send_item(CMD_QUERY, 0, 0, 0, 7'd64, 7'd63);
    drain();
  endtask

  // Mostly bursts of points into one cell followed by a query of that cell;
  // the rest is scattered points and queries of random cells.
  task automatic test_random_traffic(int shift, int thr, int car, int n_items);
    int sent, lo, hi, npts, bx, by, zb, zi;
    logic signed [15:0] x, y, z;
    write_reg(CFG_CELL_SHIFT, 16'(shift));
    write_reg(CFG_HEIGHT_THR, 16'(thr));
    write_reg(CFG_CAR_HEIGHT, 16'(car));
    lo = -(HALF_GRID << grid_shift);
    if (lo < -32768) lo = -32768;
    hi = (HALF_GRID << grid_shift) - 1;
    if (hi > 32767) hi = 32767;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 3) != 0) begin
        x  = lo + int'($urandom_range(0, hi - lo));
        y  = lo + int'($urandom_range(0, hi - lo));
        bx = (int'(x) >>> grid_shift) << grid_shift;
        by = (int'(y) >>> grid_shift) << grid_shift;
        zb = int'($urandom_range(0, 65535)) - 32768;
        npts = $urandom_range(1, 6);
        for (int i = 0; i < npts; i++) begin
          if ($urandom_range(0, 1) == 0) begin
            z = $urandom;
          end else begin
            zi = zb + int'($urandom_range(0, 700)) - 350;
            if (zi < -32768) zi = -32768;
            if (zi > 32767) zi = 32767;
            z = zi;
          end
          send_item(CMD_ADD, bx + int'($urandom_range(0, (1 << grid_shift) - 1)),
                    by + int'($urandom_range(0, (1 << grid_shift) - 1)), z, 0, 0);
        end
        send_item(CMD_QUERY, 0, 0, 0, 7'(grid_coord(x)), 7'(grid_coord(y)));
        sent += npts + 1;
      end else begin
        if ($urandom_range(0, 1) == 0)
          send_item(CMD_ADD, $urandom, $urandom, $urandom, 0, 0);
        else
          send_item(CMD_QUERY, 0, 0, 0, $urandom, $urandom);
        sent++;
      end
    end
    drain();
  endtask

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    cfg_wen        = 1'b0;
    cfg_addr       = '0;
    cfg_wdata      = '0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = 1'b0;
    out_tready     = 1'b0;
    mismatch_count = 0;
    cycle_count    = 0;
    grid_shift     = RST_CELL_SHIFT;
    height_thr     = RST_HEIGHT_THR;
    car_height     = RST_CAR_HEIGHT;
    foreach (grid_cells[i]) grid_cells[i] = '0;

    send_idle_pct = 13;
    recv_idle_pct = 47;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_unmapped_register();
    test_grid_edges();
    test_random_traffic(0, 0, -32768, 275);
    test_random_traffic(4, 100, 0, 275);

    send_idle_pct = 47;
    recv_idle_pct = 13;
    test_random_traffic(15, 65535, 32767, 275);
    test_random_traffic(12, 1000, -500, 275);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(7, 50, 1500, 275);
    test_random_traffic(9, 300, 2000, 275);

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
